/* rtl/lzss_pkg.sv */
package lzss_pkg;

  // Dictionary geometry; the size is a power of two so addresses wrap naturally.
  localparam int DICT_SIZE   = 8192;
  localparam int ADDR_W      = $clog2(DICT_SIZE);

  // Token field widths.
  localparam int OFFSET_BITS = 13;
  localparam int LENGTH_BITS = 4;
  localparam int MIN_MATCH   = 3;
  localparam int LIT_BITS    = 8;

  // Byte, size and counter widths.
  localparam int BYTE_W      = 8;
  localparam int SIZE_W      = 24;
  localparam int BITCNT_W    = $clog2(BYTE_W + 1);
  localparam int FLD_W       = (OFFSET_BITS > LIT_BITS) ? OFFSET_BITS : LIT_BITS;
  localparam int FCNT_W      = $clog2(FLD_W);
  localparam int LEN_W       = LENGTH_BITS + 1;

endpackage

/* rtl/lzss_ifs.sv */
// Compressed input channel: one word is one compressed byte.
interface lzss_in_if;
  logic                          valid;
  logic                          ready;
  logic [lzss_pkg::BYTE_W-1:0]   in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// Decompressed output channel: one word is one output byte and its end mark.
interface lzss_out_if;
  logic                          valid;
  logic                          ready;
  logic [lzss_pkg::BYTE_W-1:0]   out_byte;
  logic                          last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// Configuration channel: one word writes the output size register.
interface lzss_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lzss_pkg::SIZE_W-1:0]   output_size;

  modport source (output valid, output output_size, input ready);
  modport sink   (input valid, input output_size, output ready);
endinterface

/* rtl/lzss_ram.sv */
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

/* rtl/lzss_bitstream_decompressor.sv */
// Each accepted compressed word loads the shifter, then its bits are shifted out one at a time.
// A literal byte is emitted in the cycle its last bit is shifted in.
// Each byte copied from the dictionary goes through a registered RAM read, then emit and write.
// A stalled output register holds the parser in place.
// Reset is synchronous and active high; it clears control state, and dictionary entries not
// yet written read as zero through write tracking, so no clearing pass is needed.
module lzss_bitstream_decompressor (
  input  logic              clk,
  input  logic              rst,
  lzss_in_if.sink           in_ch,
  lzss_out_if.source        out_ch,
  lzss_cfg_if.sink          cfg
);

  typedef enum logic [1:0] {ST_PARSE, ST_RD, ST_WR} state_t;
  typedef enum logic [1:0] {PH_FLAG, PH_LIT, PH_OFF, PH_LEN} phase_t;

  state_t                             state;
  phase_t                             phase;
  logic [lzss_pkg::BYTE_W-1:0]        sh;
  logic [lzss_pkg::BITCNT_W-1:0]      cnt;
  logic [lzss_pkg::FLD_W-1:0]         fld;
  logic [lzss_pkg::FCNT_W-1:0]        fcnt;
  logic [lzss_pkg::ADDR_W-1:0]        rd_addr;
  logic [lzss_pkg::LEN_W-1:0]         rem;
  logic                               rd_ok;
  logic [lzss_pkg::ADDR_W-1:0]        head;
  logic                               upper_done;
  logic                               zero_done;
  logic [lzss_pkg::SIZE_W-1:0]        emitted;
  logic [lzss_pkg::SIZE_W-1:0]        size;
  logic                               finished;
  logic                               out_valid;
  logic [lzss_pkg::BYTE_W-1:0]        out_byte;
  logic                               out_last;

  logic                               can_emit;
  logic                               bit_in;
  logic                               lit_done;
  logic                               take_bit;
  logic                               emit_go;
  logic [lzss_pkg::BYTE_W-1:0]        emit_byte;
  logic                               emit_last;
  logic                               rd_fill_ok;
  logic [lzss_pkg::BYTE_W-1:0]        ram_q;
  logic                               in_take;
  logic                               drop;

  // Channel handshakes.
  assign in_ch.ready     = (state == ST_PARSE) && (cnt == '0);
  assign cfg.ready       = 1'b1;
  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte;
  assign out_ch.last     = out_last;

  assign in_take = in_ch.valid && in_ch.ready;
  assign drop    = finished || (emitted >= size);

  // The output register can take a new word when it is empty or being drained.
  assign can_emit = !out_valid || out_ch.ready;

  // Bit-serial parsing of the current compressed word.
  assign bit_in   = sh[lzss_pkg::BYTE_W-1];
  assign lit_done = (state == ST_PARSE) && (cnt != '0) && (phase == PH_LIT) &&
                    (fcnt == lzss_pkg::FCNT_W'(lzss_pkg::LIT_BITS - 1));
  assign take_bit = (state == ST_PARSE) && (cnt != '0) && (!lit_done || can_emit);

  // Emit source: the finished literal or the dictionary byte just read.
  always_comb begin
    emit_go   = 1'b0;
    emit_byte = {fld[lzss_pkg::LIT_BITS-2:0], bit_in};
    case (state)
      ST_PARSE: emit_go = lit_done && can_emit;
      ST_WR: begin
        emit_go   = can_emit;
        emit_byte = rd_ok ? ram_q : '0;
      end
      default: emit_go = 1'b0;
    endcase
  end

  assign emit_last = (lzss_pkg::SIZE_W'(emitted + lzss_pkg::SIZE_W'(1)) == size);

  // An entry holds written data once the write head has passed it; entry zero is written last.
  assign rd_fill_ok = (rd_addr == '0) ? zero_done : (upper_done || (rd_addr < head));

  lzss_ram #(
    .WIDTH (lzss_pkg::BYTE_W),
    .DEPTH (lzss_pkg::DICT_SIZE)
  ) u_dict (
    .clk   (clk),
    .we    (emit_go),
    .waddr (head),
    .wdata (emit_byte),
    .re    (state == ST_RD),
    .raddr (rd_addr),
    .q     (ram_q)
  );

  // Parser, copy sequencer, dictionary bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_PARSE;
      phase      <= PH_FLAG;
      cnt        <= '0;
      fcnt       <= '0;
      head       <= lzss_pkg::ADDR_W'(1);
      upper_done <= 1'b0;
      zero_done  <= 1'b0;
      emitted    <= '0;
      size       <= '0;
      finished   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        size <= cfg.output_size;
      end

      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      // Load a compressed word unless the file is already complete.
      if (in_take && !drop) begin
        sh  <= in_ch.in_byte;
        cnt <= lzss_pkg::BITCNT_W'(lzss_pkg::BYTE_W);
      end

      case (state)
        ST_PARSE: begin
          if (take_bit) begin
            sh  <= {sh[lzss_pkg::BYTE_W-2:0], 1'b0};
            cnt <= cnt - lzss_pkg::BITCNT_W'(1);
            fld <= {fld[lzss_pkg::FLD_W-2:0], bit_in};
            case (phase)
              PH_FLAG: begin
                phase <= bit_in ? PH_LIT : PH_OFF;
                fcnt  <= '0;
              end
              PH_LIT: begin
                if (lit_done) begin
                  phase <= PH_FLAG;
                end else begin
                  fcnt <= fcnt + lzss_pkg::FCNT_W'(1);
                end
              end
              PH_OFF: begin
                if (fcnt == lzss_pkg::FCNT_W'(lzss_pkg::OFFSET_BITS - 1)) begin
                  rd_addr <= lzss_pkg::ADDR_W'({fld[lzss_pkg::OFFSET_BITS-2:0], bit_in});
                  phase   <= PH_LEN;
                  fcnt    <= '0;
                end else begin
                  fcnt <= fcnt + lzss_pkg::FCNT_W'(1);
                end
              end
              PH_LEN: begin
                if (fcnt == lzss_pkg::FCNT_W'(lzss_pkg::LENGTH_BITS - 1)) begin
                  rem   <= lzss_pkg::LEN_W'({fld[lzss_pkg::LENGTH_BITS-2:0], bit_in}) +
                           lzss_pkg::LEN_W'(lzss_pkg::MIN_MATCH);
                  phase <= PH_FLAG;
                  fcnt  <= '0;
                  state <= ST_RD;
                end else begin
                  fcnt <= fcnt + lzss_pkg::FCNT_W'(1);
                end
              end
              default: phase <= PH_FLAG;
            endcase
          end
        end
        ST_RD: begin
          rd_ok   <= rd_fill_ok;
          rd_addr <= rd_addr + lzss_pkg::ADDR_W'(1);
          state   <= ST_WR;
        end
        ST_WR: begin
          if (emit_go) begin
            rem   <= rem - lzss_pkg::LEN_W'(1);
            state <= (rem == lzss_pkg::LEN_W'(1)) ? ST_PARSE : ST_RD;
          end
        end
        default: state <= ST_PARSE;
      endcase

      // Every emitted word also goes into the dictionary at the write head.
      if (emit_go) begin
        out_valid <= 1'b1;
        out_byte  <= emit_byte;
        out_last  <= emit_last;
        head      <= head + lzss_pkg::ADDR_W'(1);
        emitted   <= emitted + lzss_pkg::SIZE_W'(1);
        if (head == lzss_pkg::ADDR_W'(lzss_pkg::DICT_SIZE - 1)) begin
          upper_done <= 1'b1;
        end
        if (head == '0) begin
          zero_done <= 1'b1;
        end
        // The final byte ends the file: pending bits and any copy are dropped.
        if (emit_last) begin
          finished <= 1'b1;
          cnt      <= '0;
          phase    <= PH_FLAG;
          fcnt     <= '0;
          state    <= ST_PARSE;
        end
      end
    end
  end

  // A word marked last is only ever produced once the file is finished.
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_last) |-> finished)
    else $error("last word shown before the file was finished");

  // Once finished and drained, no further word appears.
  assert property (@(posedge clk) disable iff (rst) (finished && !out_valid) |=> !out_valid)
    else $error("word produced after the file was finished");

  // A dictionary read is always followed by its emit cycle.
  assert property (@(posedge clk) disable iff (rst) (state == ST_RD) |=> (state == ST_WR))
    else $error("dictionary read not followed by its emit cycle");

  // No compressed word is taken while a copy is in progress.
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_RD || state == ST_WR) |-> !in_ch.ready)
    else $error("input accepted during a dictionary copy");

endmodule
